// File: sv/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg
// Shared widths, register map, reset values and transaction types for the
// pinhole reprojection residual pipeline.
// ----------------------------------------------------------------------------
package prr_pkg;

  // Field widths
  localparam int ROT_W      = 18;            // signed Q2.16 rotation entry
  localparam int ROW_W      = 3 * ROT_W;     // packed rotation row
  localparam int POS_W      = 21;            // signed Q12.9 coordinate
  localparam int POSREG_W   = 3 * POS_W;     // packed camera position
  localparam int PIX_W      = 24;            // unsigned Q16.8 pixel / focal
  localparam int OUT_W      = 32;            // signed Q24.8 residual

  // Internal widths
  localparam int PD_W       = POS_W + 1;     // point minus position
  localparam int PROD_W     = ROT_W + PD_W;  // one rotation product, Q.25
  localparam int SUM_W      = PROD_W + 2;    // sum of three products
  localparam int FRAC_DROP  = 16;            // Q.25 -> Q.9
  localparam int CAM_W      = SUM_W - FRAC_DROP; // camera-frame coordinate
  localparam int DEP_W      = CAM_W - 1;     // positive clamped depth
  localparam int NUM_W      = PIX_W + 1 + CAM_W; // focal * coordinate
  localparam int MAG_W      = NUM_W - 1;     // magnitude of the numerator
  localparam int DIV_W      = MAG_W + 2;     // divider dividend / quotient
  localparam int DEN_W      = DEP_W + 1;     // divider divisor (2 * depth)
  localparam int DIV_STEPS  = 2;             // quotient bits per stage
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int RES_W      = DIV_W + 2;     // exact residual before clamp

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_CAM_POS  = 3'd3,
    REG_FOCAL_X  = 3'd4,
    REG_FOCAL_Y  = 3'd5,
    REG_CENTER_X = 3'd6,
    REG_CENTER_Y = 3'd7
  } cfg_reg_t;

  // Reset values: identity rotation, origin, unit focal length
  localparam logic [ROW_W-1:0]    ROT_ROW0_RST = 54'd65536;
  localparam logic [ROW_W-1:0]    ROT_ROW1_RST = 54'd17179869184;
  localparam logic [ROW_W-1:0]    ROT_ROW2_RST = 54'd4503599627370496;
  localparam logic [POSREG_W-1:0] CAM_POS_RST  = '0;
  localparam logic [PIX_W-1:0]    FOCAL_RST    = 24'd256;
  localparam logic [PIX_W-1:0]    CENTER_RST   = '0;

  // Residual saturation limits
  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Live configuration
  typedef struct packed {
    logic [2:0][ROW_W-1:0] rot;
    logic [POSREG_W-1:0]   pos;
    logic [PIX_W-1:0]      fx;
    logic [PIX_W-1:0]      fy;
    logic [PIX_W-1:0]      cx;
    logic [PIX_W-1:0]      cy;
  } cfg_t;

  // Observation payload
  typedef struct packed {
    logic [POS_W-1:0] point_x;
    logic [POS_W-1:0] point_y;
    logic [POS_W-1:0] point_z;
    logic [PIX_W-1:0] seen_u;
    logic [PIX_W-1:0] seen_v;
  } obs_t;

  // Data that rides alongside the divider
  typedef struct packed {
    logic             neg_u;
    logic             neg_v;
    logic             clamp;
    logic [PIX_W-1:0] seen_u;
    logic [PIX_W-1:0] seen_v;
  } side_t;

  // Transform -> divider
  typedef struct packed {
    logic [DIV_W-1:0] num_u;
    logic [DIV_W-1:0] num_v;
    logic [DEN_W-1:0] den;
    side_t            side;
  } dv_t;

  // Divider -> residual
  typedef struct packed {
    logic [DIV_W-1:0] quo_u;
    logic [DIV_W-1:0] quo_v;
    side_t            side;
  } quo_t;

  // Result payload
  typedef struct packed {
    logic [OUT_W-1:0] residual_u;
    logic [OUT_W-1:0] residual_v;
    logic             depth_clamped;
    logic             saturated;
  } res_t;

endpackage

// File: sv/prr_obs_if.sv
// ----------------------------------------------------------------------------
// prr_obs_if
// Observation channel: world point and observed pixel, valid/ready.
// ----------------------------------------------------------------------------
interface prr_obs_if;
  import prr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] point_x;
  logic signed [POS_W-1:0] point_y;
  logic signed [POS_W-1:0] point_z;
  logic [PIX_W-1:0]        seen_u;
  logic [PIX_W-1:0]        seen_v;

  modport source (output valid, point_x, point_y, point_z, seen_u, seen_v,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, seen_u, seen_v,
                  output ready);
endinterface

// File: sv/prr_res_if.sv
// ----------------------------------------------------------------------------
// prr_res_if
// Result channel: residual pair and status flags, valid/ready.
// ----------------------------------------------------------------------------
interface prr_res_if;
  import prr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] residual_u;
  logic signed [OUT_W-1:0] residual_v;
  logic                    depth_clamped;
  logic                    saturated;

  modport source (output valid, residual_u, residual_v, depth_clamped, saturated,
                  input ready);
  modport sink   (input valid, residual_u, residual_v, depth_clamped, saturated,
                  output ready);
endinterface

// File: sv/prr_cfg_if.sv
// ----------------------------------------------------------------------------
// prr_cfg_if
// Configuration write channel: register index and write data, valid/ready.
// ----------------------------------------------------------------------------
interface prr_cfg_if;
  import prr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/prr_cfg.sv
// ----------------------------------------------------------------------------
// prr_cfg
// Configuration register file. Every write transaction completes at once;
// all eight indexes of the map are in use.
// ----------------------------------------------------------------------------
module prr_cfg (
  input  logic          clk,
  input  logic          rst,
  prr_cfg_if.sink       wr,
  output prr_pkg::cfg_t cfg
);
  import prr_pkg::*;

  assign wr.ready = 1'b1;

  // Register writes, extra data bits dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot[0] <= ROT_ROW0_RST;
      cfg.rot[1] <= ROT_ROW1_RST;
      cfg.rot[2] <= ROT_ROW2_RST;
      cfg.pos    <= CAM_POS_RST;
      cfg.fx     <= FOCAL_RST;
      cfg.fy     <= FOCAL_RST;
      cfg.cx     <= CENTER_RST;
      cfg.cy     <= CENTER_RST;
    end else if (wr.valid) begin
      case (cfg_reg_t'(wr.index))
        REG_ROT_ROW0: cfg.rot[0] <= wr.data[ROW_W-1:0];
        REG_ROT_ROW1: cfg.rot[1] <= wr.data[ROW_W-1:0];
        REG_ROT_ROW2: cfg.rot[2] <= wr.data[ROW_W-1:0];
        REG_CAM_POS:  cfg.pos    <= wr.data[POSREG_W-1:0];
        REG_FOCAL_X:  cfg.fx     <= wr.data[PIX_W-1:0];
        REG_FOCAL_Y:  cfg.fy     <= wr.data[PIX_W-1:0];
        REG_CENTER_X: cfg.cx     <= wr.data[PIX_W-1:0];
        REG_CENTER_Y: cfg.cy     <= wr.data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/prr_xform.sv
// ----------------------------------------------------------------------------
// prr_xform
// Seven-stage front end: translate, rotate, round to Q.9, clamp depth,
// scale by focal length and build the divider operands.
// ----------------------------------------------------------------------------
module prr_xform (
  input  logic          clk,
  input  logic          rst,
  input  prr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  prr_pkg::obs_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prr_pkg::dv_t  out_data
);
  import prr_pkg::*;

  localparam int NSTG = 7;

  typedef struct packed {
    logic [2:0][PD_W-1:0] p;
    logic [PIX_W-1:0]     su;
    logic [PIX_W-1:0]     sv;
  } s1_t;

  typedef struct packed {
    logic [2:0][2:0][PROD_W-1:0] prod;
    logic [PIX_W-1:0]            su;
    logic [PIX_W-1:0]            sv;
  } s2_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [PIX_W-1:0]      su;
    logic [PIX_W-1:0]      sv;
  } s3_t;

  typedef struct packed {
    logic [CAM_W-1:0] xc;
    logic [CAM_W-1:0] yc;
    logic [DEP_W-1:0] d;
    logic             clamp;
    logic [PIX_W-1:0] su;
    logic [PIX_W-1:0] sv;
  } s4_t;

  typedef struct packed {
    logic [NUM_W-1:0] nu;
    logic [NUM_W-1:0] nv;
    logic [DEP_W-1:0] d;
    logic             clamp;
    logic [PIX_W-1:0] su;
    logic [PIX_W-1:0] sv;
  } s5_t;

  typedef struct packed {
    logic [MAG_W-1:0] mu;
    logic [MAG_W-1:0] mv;
    logic             neg_u;
    logic             neg_v;
    logic [DEP_W-1:0] d;
    logic             clamp;
    logic [PIX_W-1:0] su;
    logic [PIX_W-1:0] sv;
  } s6_t;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vin;

  s1_t  r1, r1_next;
  s2_t  r2, r2_next;
  s3_t  r3, r3_next;
  s4_t  r4, r4_next;
  s5_t  r5, r5_next;
  s6_t  r6, r6_next;
  dv_t  r7, r7_next;

  // Stage handshake: a stage loads when empty or when the next one loads
  assign adv[NSTG-1] = !v[NSTG-1] || out_ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign vin       = {v[NSTG-2:0], in_valid};
  assign in_ready  = adv[0];
  assign out_valid = v[NSTG-1];
  assign out_data  = r7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) v[k] <= vin[k];
      end
    end
  end

  // S1: point minus camera position, exact in 22 bits
  always_comb begin
    logic [2:0][POS_W-1:0] pt;
    logic [POS_W-1:0]      tr;
    pt[0] = in_data.point_x;
    pt[1] = in_data.point_y;
    pt[2] = in_data.point_z;
    r1_next.su = in_data.seen_u;
    r1_next.sv = in_data.seen_v;
    for (int k = 0; k < 3; k++) begin
      tr = cfg.pos[k*POS_W +: POS_W];
      r1_next.p[k] = {pt[k][POS_W-1], pt[k]} - {tr[POS_W-1], tr};
    end
  end

  // S2: nine rotation products, Q2.16 x Q.9
  always_comb begin
    logic signed [PROD_W-1:0] pr;
    r2_next.su = r1.su;
    r2_next.sv = r1.sv;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pr = $signed(cfg.rot[r][c*ROT_W +: ROT_W]) * $signed(r1.p[c]);
        r2_next.prod[r][c] = pr;
      end
    end
  end

  // S3: row sums in Q.25
  always_comb begin
    r3_next.su = r2.su;
    r3_next.sv = r2.sv;
    for (int r = 0; r < 3; r++) begin
      r3_next.sum[r] = {{(SUM_W-PROD_W){r2.prod[r][0][PROD_W-1]}}, r2.prod[r][0]}
                     + {{(SUM_W-PROD_W){r2.prod[r][1][PROD_W-1]}}, r2.prod[r][1]}
                     + {{(SUM_W-PROD_W){r2.prod[r][2][PROD_W-1]}}, r2.prod[r][2]};
    end
  end

  // S4: round half up to Q.9, floor depth at one LSB
  always_comb begin
    logic [2:0][SUM_W-1:0] rs;
    logic [CAM_W-1:0]      zc;
    for (int r = 0; r < 3; r++) begin
      rs[r] = r3.sum[r] + SUM_W'(1 << (FRAC_DROP - 1));
    end
    zc            = rs[2][SUM_W-1:FRAC_DROP];
    r4_next.xc    = rs[0][SUM_W-1:FRAC_DROP];
    r4_next.yc    = rs[1][SUM_W-1:FRAC_DROP];
    r4_next.clamp = zc[CAM_W-1] || (zc == '0);
    r4_next.d     = r4_next.clamp ? DEP_W'(1) : zc[DEP_W-1:0];
    r4_next.su    = r3.su;
    r4_next.sv    = r3.sv;
  end

  // S5: focal length times camera-frame coordinate
  always_comb begin
    logic signed [NUM_W-1:0] pu;
    logic signed [NUM_W-1:0] pv;
    pu = $signed({1'b0, cfg.fx}) * $signed(r4.xc);
    pv = $signed({1'b0, cfg.fy}) * $signed(r4.yc);
    r5_next.nu    = pu;
    r5_next.nv    = pv;
    r5_next.d     = r4.d;
    r5_next.clamp = r4.clamp;
    r5_next.su    = r4.su;
    r5_next.sv    = r4.sv;
  end

  // S6: sign and magnitude of the numerators
  always_comb begin
    logic [NUM_W-1:0] au;
    logic [NUM_W-1:0] av;
    au = r5.nu[NUM_W-1] ? (NUM_W'(0) - r5.nu) : r5.nu;
    av = r5.nv[NUM_W-1] ? (NUM_W'(0) - r5.nv) : r5.nv;
    r6_next.mu    = au[MAG_W-1:0];
    r6_next.mv    = av[MAG_W-1:0];
    r6_next.neg_u = r5.nu[NUM_W-1];
    r6_next.neg_v = r5.nv[NUM_W-1];
    r6_next.d     = r5.d;
    r6_next.clamp = r5.clamp;
    r6_next.su    = r5.su;
    r6_next.sv    = r5.sv;
  end

  // S7: round-to-nearest operands, (2*mag + d) / (2*d)
  always_comb begin
    r7_next.num_u       = {1'b0, r6.mu, 1'b0} + {{(DIV_W-DEP_W){1'b0}}, r6.d};
    r7_next.num_v       = {1'b0, r6.mv, 1'b0} + {{(DIV_W-DEP_W){1'b0}}, r6.d};
    r7_next.den         = {r6.d, 1'b0};
    r7_next.side.neg_u  = r6.neg_u;
    r7_next.side.neg_v  = r6.neg_v;
    r7_next.side.clamp  = r6.clamp;
    r7_next.side.seen_u = r6.su;
    r7_next.side.seen_v = r6.sv;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) r1 <= r1_next;
    if (adv[1]) r2 <= r2_next;
    if (adv[2]) r3 <= r3_next;
    if (adv[3]) r4 <= r4_next;
    if (adv[4]) r5 <= r5_next;
    if (adv[5]) r6 <= r6_next;
    if (adv[6]) r7 <= r7_next;
  end

endmodule

// File: sv/prr_div.sv
// ----------------------------------------------------------------------------
// prr_div
// Pipelined restoring divider for the u and v lanes, sharing one divisor.
// Each stage retires DIV_STEPS quotient bits; the quotient shifts into the
// dividend register as its bits are consumed.
// ----------------------------------------------------------------------------
module prr_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prr_pkg::dv_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prr_pkg::quo_t out_data
);
  import prr_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] num;
  } lane_t;

  typedef struct packed {
    lane_t            u;
    lane_t            v;
    logic [DEN_W-1:0] den;
    side_t            side;
  } stage_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic lane_t div_step(lane_t a, logic [DEN_W-1:0] den);
    logic [DEN_W:0] r2;
    logic           q;
    lane_t          o;
    r2 = {a.rem, a.num[DIV_W-1]};
    q  = (r2 >= {1'b0, den});
    if (q) r2 = r2 - {1'b0, den};
    o.rem = r2[DEN_W-1:0];
    o.num = {a.num[DIV_W-2:0], q};
    return o;
  endfunction

  logic   v   [DIV_STAGES];
  logic   adv [DIV_STAGES];
  stage_t st  [DIV_STAGES];

  assign adv[DIV_STAGES-1] = !v[DIV_STAGES-1] || out_ready;
  assign in_ready          = adv[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    stage_t src;
    stage_t nxt;
    logic   vin;

    if (k == 0) begin : g_first
      always_comb begin
        src.u.rem = '0;
        src.u.num = in_data.num_u;
        src.v.rem = '0;
        src.v.num = in_data.num_v;
        src.den   = in_data.den;
        src.side  = in_data.side;
      end
      assign vin = in_valid;
    end else begin : g_next
      assign src = st[k-1];
      assign vin = v[k-1];
      assign adv[k-1] = !v[k-1] || adv[k];
    end

    // Quotient bits for this stage
    always_comb begin
      nxt = src;
      for (int i = 0; i < DIV_STEPS; i++) begin
        nxt.u = div_step(nxt.u, nxt.den);
        nxt.v = div_step(nxt.v, nxt.den);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (adv[k]) v[k] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv[k]) st[k] <= nxt;
    end
  end

  assign out_valid      = v[DIV_STAGES-1];
  assign out_data.quo_u = st[DIV_STAGES-1].u.num;
  assign out_data.quo_v = st[DIV_STAGES-1].v.num;
  assign out_data.side  = st[DIV_STAGES-1].side;

endmodule

// File: sv/prr_res.sv
// ----------------------------------------------------------------------------
// prr_res
// Three-stage back end: restore sign, add principal point and subtract the
// observed pixel, then saturate into the output register.
// ----------------------------------------------------------------------------
module prr_res (
  input  logic          clk,
  input  logic          rst,
  input  prr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  prr_pkg::quo_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prr_pkg::res_t out_data
);
  import prr_pkg::*;

  localparam int NSTG = 3;

  typedef struct packed {
    logic [DIV_W-1:0] pu;
    logic [DIV_W-1:0] pv;
    logic             clamp;
    logic [PIX_W-1:0] su;
    logic [PIX_W-1:0] sv;
  } t1_t;

  typedef struct packed {
    logic [RES_W-1:0] ru;
    logic [RES_W-1:0] rv;
    logic             clamp;
  } t2_t;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vin;

  t1_t  q1, q1_next;
  t2_t  q2, q2_next;
  res_t q3, q3_next;

  assign adv[NSTG-1] = !v[NSTG-1] || out_ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign vin       = {v[NSTG-2:0], in_valid};
  assign in_ready  = adv[0];
  assign out_valid = v[NSTG-1];
  assign out_data  = q3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) v[k] <= vin[k];
      end
    end
  end

  // T1: signed projection, Q.8
  always_comb begin
    q1_next.pu    = in_data.side.neg_u ? (DIV_W'(0) - in_data.quo_u) : in_data.quo_u;
    q1_next.pv    = in_data.side.neg_v ? (DIV_W'(0) - in_data.quo_v) : in_data.quo_v;
    q1_next.clamp = in_data.side.clamp;
    q1_next.su    = in_data.side.seen_u;
    q1_next.sv    = in_data.side.seen_v;
  end

  // T2: exact residual, projection + center - observed
  always_comb begin
    q2_next.ru = {{(RES_W-DIV_W){q1.pu[DIV_W-1]}}, q1.pu}
               + {{(RES_W-PIX_W){1'b0}}, cfg.cx}
               - {{(RES_W-PIX_W){1'b0}}, q1.su};
    q2_next.rv = {{(RES_W-DIV_W){q1.pv[DIV_W-1]}}, q1.pv}
               + {{(RES_W-PIX_W){1'b0}}, cfg.cy}
               - {{(RES_W-PIX_W){1'b0}}, q1.sv};
    q2_next.clamp = q1.clamp;
  end

  // T3: clamp to 32 bits; a value on a limit is not flagged
  always_comb begin
    logic [RES_W-OUT_W:0] hu;
    logic [RES_W-OUT_W:0] hv;
    logic                 ok_u;
    logic                 ok_v;
    hu   = q2.ru[RES_W-1:OUT_W-1];
    hv   = q2.rv[RES_W-1:OUT_W-1];
    ok_u = (&hu) || !(|hu);
    ok_v = (&hv) || !(|hv);
    q3_next.residual_u    = ok_u ? q2.ru[OUT_W-1:0] : (q2.ru[RES_W-1] ? SAT_MIN : SAT_MAX);
    q3_next.residual_v    = ok_v ? q2.rv[OUT_W-1:0] : (q2.rv[RES_W-1] ? SAT_MIN : SAT_MAX);
    q3_next.depth_clamped = q2.clamp;
    q3_next.saturated     = !ok_u || !ok_v;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) q1 <= q1_next;
    if (adv[1]) q2 <= q2_next;
    if (adv[2]) q3 <= q3_next;
  end

endmodule

// File: sv/pinhole_reprojection_residual.sv
// ----------------------------------------------------------------------------
// pinhole_reprojection_residual
// Streaming pinhole-camera reprojection residual: one observation in, one
// residual pair out.
// ----------------------------------------------------------------------------
// Takes one observation per clock while the result side does not stall, and
// returns one result per observation, in order. The pipeline is made of
// 7 stages of translate/rotate/round/scale, 26 divider stages retiring two
// quotient bits each (the 52-bit round-to-nearest division sets the depth),
// and 3 stages of sign, offset and saturation ending in the output register.
// Every stage holds its item until the next stage is free, so bubbles are
// squeezed out and input stays open while results wait until every stage is
// full; obs.ready depends combinationally on res.ready. Configuration
// registers feed the pipeline directly and take effect at once, so write them
// only while no transaction is in flight. Configuration writes never stall.
module pinhole_reprojection_residual (
  input  logic     clk,
  input  logic     rst,
  prr_obs_if.sink  obs,
  prr_res_if.source res,
  prr_cfg_if.sink  cfg
);
  import prr_pkg::*;

  cfg_t cfg_q;
  obs_t obs_data;
  dv_t  xf_data;
  quo_t dv_data;
  res_t out_data;
  logic xf_valid, xf_ready;
  logic dv_valid, dv_ready;

  assign obs_data.point_x = obs.point_x;
  assign obs_data.point_y = obs.point_y;
  assign obs_data.point_z = obs.point_z;
  assign obs_data.seen_u  = obs.seen_u;
  assign obs_data.seen_v  = obs.seen_v;

  prr_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .wr  (cfg),
    .cfg (cfg_q)
  );

  prr_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (obs.valid),
    .in_ready  (obs.ready),
    .in_data   (obs_data),
    .out_valid (xf_valid),
    .out_ready (xf_ready),
    .out_data  (xf_data)
  );

  prr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .in_ready  (xf_ready),
    .in_data   (xf_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  prr_res u_res (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  assign res.residual_u    = out_data.residual_u;
  assign res.residual_v    = out_data.residual_v;
  assign res.depth_clamped = out_data.depth_clamped;
  assign res.saturated     = out_data.saturated;

endmodule
